// ===== src/assert_macros.svh =====
// Assertion helpers for the register slave. Both macros are clocked on the
// rising edge and are switched off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold in the same cycle.
`define ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Property that must hold in the cycle after the trigger.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/stbrs_pkg.sv =====
// ----------------------------------------------------------------------------
// stbrs_pkg
// Constants, types and helpers shared by the three-byte register slave.
// ----------------------------------------------------------------------------
`default_nettype none

package stbrs_pkg;

   localparam int BYTE_W     = 8;
   localparam int REG_COUNT  = 1024;
   localparam int ADDR_W     = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
   localparam int FRAME_AW   = 15;
   localparam int ID_ADDRESS = 'h2CE;
   localparam logic [BYTE_W-1:0] ID_VALUE = 8'h16;

   // position of the next beat within a frame; the spare code acts as data
   typedef enum logic [1:0] {
      PHASE_CMD  = 2'd0,
      PHASE_ADDR = 2'd1,
      PHASE_DATA = 2'd2
   } phase_type;

   // bus bytes travel LSB first
   function automatic logic [BYTE_W-1:0] mirror_byte(input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] r;
      for (int i = 0; i < BYTE_W; i++) begin
         r[i] = b[BYTE_W-1-i];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== src/stbrs_ram.sv =====
// ----------------------------------------------------------------------------
// stbrs_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module stbrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/spi_three_byte_register_slave.sv =====
// Response: the response beat to an accepted beat is registered and appears in the cycle after it.
// Throughput: one beat per cycle while req_stall is low; the store is read on the second beat of a
// frame so the data is waiting in the RAM read register by the third.
// Reset: synchronous; phase, flags and rsp_valid clear at once, then a clearing
// pass writes every register entry with zero, or the ID value at the ID address,
// while req_stall stays high.
// ----------------------------------------------------------------------------
// spi_three_byte_register_slave
// Byte-wide register slave decoding read/write frames of three bus bytes.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module spi_three_byte_register_slave (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic [stbrs_pkg::BYTE_W-1:0] req_rx_byte,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic      [stbrs_pkg::BYTE_W-1:0] rsp_tx_byte,
   output logic                            rsp_frame_end
);

   localparam int AW  = stbrs_pkg::ADDR_W;
   localparam int FAW = stbrs_pkg::FRAME_AW;
   localparam int BW  = stbrs_pkg::BYTE_W;

   // clearing pass
   logic          clearing_ff, clearing_in;
   logic [AW-1:0] clr_idx_ff, clr_idx_in;

   // frame decode state
   stbrs_pkg::phase_type phase_ff, phase_in;
   logic                 read_flag_ff, read_flag_in;
   logic [FAW-1:0]       frame_addr_ff, frame_addr_in;
   logic                 in_range_ff, in_range_in;

   // response register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [BW-1:0] tx_byte_ff, tx_byte_in;
   logic          frame_end_ff, frame_end_in;

   logic           accept;
   logic [BW-1:0]  logical;
   logic [FAW-1:0] full_addr;
   logic           ram_wr_en, ram_rd_en;
   logic [AW-1:0]  ram_wr_addr;
   logic [BW-1:0]  ram_wr_data, ram_rd_data;
   logic           store_wr;
   logic [BW-1:0]  answer;

   // assertion terms
   logic           data_beat;
   logic           mid_frame_rsp;
   logic           frame_end_rsp;

   assign req_stall = reset || clearing_ff || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign logical   = stbrs_pkg::mirror_byte(req_rx_byte);
   assign full_addr = {frame_addr_ff[FAW-1:BW], logical};

   always_comb begin
      clearing_in   = clearing_ff;
      clr_idx_in    = clr_idx_ff;
      phase_in      = phase_ff;
      read_flag_in  = read_flag_ff;
      frame_addr_in = frame_addr_ff;
      in_range_in   = in_range_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      tx_byte_in    = tx_byte_ff;
      frame_end_in  = frame_end_ff;
      ram_rd_en     = 1'b0;
      store_wr      = 1'b0;
      answer        = '0;

      if (clearing_ff) begin
         clr_idx_in = clr_idx_ff + 1'b1;
         if (clr_idx_ff == AW'(stbrs_pkg::REG_COUNT - 1)) begin
            clearing_in = 1'b0;
         end
      end

      if (accept) begin
         rsp_valid_in = 1'b1;
         frame_end_in = 1'b0;
         unique case (phase_ff)
            stbrs_pkg::PHASE_CMD: begin
               read_flag_in  = logical[BW-1];
               frame_addr_in = {logical[BW-2:0], {BW{1'b0}}};
               phase_in      = stbrs_pkg::PHASE_ADDR;
            end
            stbrs_pkg::PHASE_ADDR: begin
               frame_addr_in = full_addr;
               in_range_in   = {1'b0, full_addr} < (FAW+1)'(stbrs_pkg::REG_COUNT);
               ram_rd_en     = 1'b1;
               phase_in      = stbrs_pkg::PHASE_DATA;
            end
            default: begin
               if (in_range_ff) begin
                  if (read_flag_ff) begin
                     answer = ram_rd_data;
                  end else begin
                     store_wr = 1'b1;
                  end
               end
               frame_end_in = 1'b1;
               phase_in     = stbrs_pkg::PHASE_CMD;
            end
         endcase
         tx_byte_in = stbrs_pkg::mirror_byte(answer);
      end
   end

   // clearing pass owns the write port until it finishes
   always_comb begin
      if (clearing_ff) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_idx_ff;
         ram_wr_data = (clr_idx_ff == AW'(stbrs_pkg::ID_ADDRESS)) ? stbrs_pkg::ID_VALUE : '0;
      end else begin
         ram_wr_en   = store_wr;
         ram_wr_addr = frame_addr_ff[AW-1:0];
         ram_wr_data = logical;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff   <= 1'b1;
         clr_idx_ff    <= '0;
         phase_ff      <= stbrs_pkg::PHASE_CMD;
         read_flag_ff  <= 1'b0;
         frame_addr_ff <= '0;
         in_range_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         clearing_ff   <= clearing_in;
         clr_idx_ff    <= clr_idx_in;
         phase_ff      <= phase_in;
         read_flag_ff  <= read_flag_in;
         frame_addr_ff <= frame_addr_in;
         in_range_ff   <= in_range_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tx_byte_ff   <= tx_byte_in;
      frame_end_ff <= frame_end_in;
   end

   stbrs_ram #(
      .WIDTH(BW),
      .DEPTH(stbrs_pkg::REG_COUNT)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (full_addr[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_tx_byte   = tx_byte_ff;
   assign rsp_frame_end = frame_end_ff;

   assign data_beat     = accept && (phase_ff == stbrs_pkg::PHASE_DATA);
   assign mid_frame_rsp = rsp_valid_ff && !frame_end_ff;
   assign frame_end_rsp = rsp_valid_ff && frame_end_ff;

   `ASSERT_NOW(a_no_beat_while_clearing, clock, reset, clearing_ff, req_stall, "beat in clear")
   `ASSERT_NOW(a_zero_mid_frame, clock, reset, mid_frame_rsp, tx_byte_ff == '0, "tx not zero")
   `ASSERT_NEXT(a_data_beat_ends_frame, clock, reset, data_beat, frame_end_rsp, "no frame end")

endmodule

`default_nettype wire
